[hdl/tcp_connection_control_block_core_defines.svh]
// Assertion macros shared by the connection control block modules.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef TCP_CONNECTION_CONTROL_BLOCK_CORE_DEFINES_SVH
`define TCP_CONNECTION_CONTROL_BLOCK_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/tcb_pkg.sv]
// Types, codes and helper functions of the connection control block.
// No dependencies; used by every module of the block.
`default_nettype none

package tcb_pkg;

	// Input action codes.
	localparam logic [2:0] ACT_OPEN   = 3'd0;
	localparam logic [2:0] ACT_SEG    = 3'd1;
	localparam logic [2:0] ACT_SEND   = 3'd2;
	localparam logic [2:0] ACT_READ   = 3'd3;
	localparam logic [2:0] ACT_EXPIRE = 3'd4;

	// Bit positions in the TCP flag byte.
	localparam int FLAG_FIN = 0;
	localparam int FLAG_SYN = 1;
	localparam int FLAG_PSH = 3;
	localparam int FLAG_ACK = 4;

	// Configuration register indexes.
	localparam logic [1:0] REG_INIT_SEQ = 2'd0;
	localparam logic [1:0] REG_RCV_CAP  = 2'd1;
	localparam logic [1:0] REG_MSS      = 2'd2;

	localparam logic [31:0] INIT_SEQ_RESET = 32'd0;
	localparam logic [15:0] RCV_CAP_RESET  = 16'd65535;
	localparam logic [15:0] MSS_RESET      = 16'd1460;

	typedef enum logic [2:0] {
		ST_CLOSED    = 3'd0,
		ST_SYN_SENT  = 3'd1,
		ST_SYN_RCVD  = 3'd2,
		ST_ESTAB     = 3'd3,
		ST_FIN_WAIT1 = 3'd4,
		ST_FIN_WAIT2 = 3'd5,
		ST_TIME_WAIT = 3'd6
	} conn_state_t;

	typedef enum logic [1:0] {
		TX_NONE   = 2'd0,
		TX_ACK    = 2'd1,
		TX_SYN    = 2'd2,
		TX_SYNACK = 2'd3
	} tx_kind_t;

	typedef enum logic [2:0] {
		EV_NONE,
		EV_OPEN,
		EV_SEG,
		EV_SEND,
		EV_READ,
		EV_EXPIRE
	} event_kind_t;

	// Classified event as it waits in the queue.
	typedef struct packed {
		event_kind_t kind;
		logic        flag_fin;
		logic        flag_syn;
		logic        flag_psh;
		logic        flag_ack;
		logic        header_ok;
		logic [31:0] seg_seq;
		logic [31:0] seg_seq_p1;
		logic [31:0] seg_ack;
		logic [15:0] seg_window;
		logic [15:0] seg_payload_len;
		logic        payload_nz;
		logic [15:0] byte_count;
	} tcb_cmd_t;

	// One result item.
	typedef struct packed {
		tx_kind_t    transmit;
		logic [31:0] tx_seq;
		logic [31:0] tx_ack;
		logic [2:0]  conn_state_now;
		logic        dropped;
		logic [15:0] accepted_bytes;
		logic        wake_reader;
		logic        wake_sender;
		logic        start_wait_timer;
		logic [15:0] rcv_fill_now;
	} tcb_result_t;

	function automatic logic [15:0] min16(input logic [15:0] a, input logic [15:0] b);
		return (a < b) ? a : b;
	endfunction

endpackage

`default_nettype wire

[hdl/tcb_front.sv]
// Front end: accepts input items and classifies them into queue commands.
// Depends on tcb_pkg.
`default_nettype none

module tcb_front (
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [127:0]      s_tdata,
	input  wire logic [7:0]        s_tuser,
	input  wire logic              queue_full,
	output logic                   push,
	output tcb_pkg::tcb_cmd_t      cmd
);

	logic [7:0] flags;

	assign flags    = s_tdata[7:0];
	assign s_tready = !queue_full;
	assign push     = s_tvalid && !queue_full;

	always_comb begin
		cmd                 = '0;
		cmd.flag_fin        = flags[tcb_pkg::FLAG_FIN];
		cmd.flag_syn        = flags[tcb_pkg::FLAG_SYN];
		cmd.flag_psh        = flags[tcb_pkg::FLAG_PSH];
		cmd.flag_ack        = flags[tcb_pkg::FLAG_ACK];
		cmd.seg_seq         = s_tdata[39:8];
		cmd.seg_seq_p1      = s_tdata[39:8] + 32'd1;
		cmd.seg_ack         = s_tdata[71:40];
		cmd.seg_window      = s_tdata[87:72];
		cmd.seg_payload_len = s_tdata[103:88];
		cmd.payload_nz      = (s_tdata[103:88] != 16'd0);
		cmd.header_ok       = s_tdata[104];
		cmd.byte_count      = s_tdata[120:105];
		case (s_tuser[2:0])
			tcb_pkg::ACT_OPEN:   cmd.kind = tcb_pkg::EV_OPEN;
			tcb_pkg::ACT_SEG:    cmd.kind = tcb_pkg::EV_SEG;
			tcb_pkg::ACT_SEND:   cmd.kind = tcb_pkg::EV_SEND;
			tcb_pkg::ACT_READ:   cmd.kind = tcb_pkg::EV_READ;
			tcb_pkg::ACT_EXPIRE: cmd.kind = tcb_pkg::EV_EXPIRE;
			default:             cmd.kind = tcb_pkg::EV_NONE;
		endcase
	end

endmodule

`default_nettype wire

[hdl/tcb_queue.sv]
// Short flip-flop queue of classified commands between front and back end.
// Depends on tcb_pkg and the assertion macro header.
`default_nettype none
`include "tcp_connection_control_block_core_defines.svh"

module tcb_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire tcb_pkg::tcb_cmd_t push_data,
	output logic                   full,
	input  wire logic              pop,
	output logic                   valid,
	output tcb_pkg::tcb_cmd_t      head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tcb_pkg::tcb_cmd_t entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full  = (count_q == CNT_W'(DEPTH));
	assign valid = (count_q != '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`TCB_ASSERT_NOW(a_no_pop_empty, count_q == '0, !pop, "queue popped while empty")
	`TCB_ASSERT_NEXT(a_push_fills, push && !pop, count_q != '0, "queue lost a pushed command")

endmodule

`default_nettype wire

[hdl/tcb_back.sv]
// Back end: executes queued commands against the connection state and
// holds the result register. Depends on tcb_pkg and the assertion macro header.
`default_nettype none
`include "tcp_connection_control_block_core_defines.svh"

module tcb_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [31:0]       cfg_data,
	input  wire logic              cmd_valid,
	input  wire tcb_pkg::tcb_cmd_t cmd,
	output logic                   cmd_pop,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output tcb_pkg::tcb_result_t   res
);

	// Configuration registers.
	logic [31:0] init_seq_q;
	logic [15:0] rcv_cap_q;
	logic [15:0] mss_q;

	// Connection state. The peer's initial sequence number affects no result
	// and is not kept.
	tcb_pkg::conn_state_t st_q, st_d;
	logic [31:0] snd_una_q, snd_una_d;
	logic [31:0] snd_nxt_q, snd_nxt_d;
	logic [15:0] snd_wnd_q, snd_wnd_d;
	logic [31:0] rcv_nxt_q, rcv_nxt_d;
	logic [15:0] fill_q, fill_d;

	logic                 res_valid_q;
	tcb_pkg::tcb_result_t res_q, res_d;

	logic [15:0] space;
	logic [15:0] seg_n;
	logic [15:0] rd_n;
	logic [31:0] flight;
	logic [15:0] room;
	logic [15:0] snd_n;
	logic        in_win;
	logic        syn_ok;
	logic [31:0] una_sel;
	logic        want_ack;
	logic        go;
	logic [15:0] pay_n;
	logic        fin_inc;

	assign cmd_pop   = cmd_valid && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign space  = (fill_q >= rcv_cap_q) ? 16'd0 : rcv_cap_q - fill_q;
	assign seg_n  = tcb_pkg::min16(cmd.seg_payload_len, space);
	assign rd_n   = tcb_pkg::min16(cmd.byte_count, fill_q);
	assign flight = snd_nxt_q - snd_una_q;
	assign room   = (flight >= {16'd0, snd_wnd_q}) ? 16'd0 : snd_wnd_q - flight[15:0];
	assign snd_n  = tcb_pkg::min16(cmd.byte_count, tcb_pkg::min16(mss_q, room));
	assign in_win = (snd_una_q < cmd.seg_ack) && (cmd.seg_ack <= snd_nxt_q);
	assign syn_ok = cmd.flag_ack && (snd_una_q <= cmd.seg_ack) && (cmd.seg_ack <= snd_nxt_q);
	assign una_sel = syn_ok ? cmd.seg_ack : snd_una_q;

	always_comb begin
		st_d      = st_q;
		snd_una_d = snd_una_q;
		snd_nxt_d = snd_nxt_q;
		snd_wnd_d = snd_wnd_q;
		rcv_nxt_d = rcv_nxt_q;
		fill_d    = fill_q;
		res_d     = '0;
		want_ack  = 1'b0;
		go        = 1'b0;
		pay_n     = 16'd0;
		fin_inc   = 1'b0;
		case (cmd.kind)
			tcb_pkg::EV_OPEN: begin
				if (st_q == tcb_pkg::ST_CLOSED) begin
					snd_una_d      = init_seq_q;
					snd_nxt_d      = init_seq_q + 32'd1;
					snd_wnd_d      = 16'd0;
					fill_d         = 16'd0;
					res_d.tx_seq   = init_seq_q;
					res_d.tx_ack   = rcv_nxt_q;
					res_d.transmit = tcb_pkg::TX_SYN;
					st_d           = tcb_pkg::ST_SYN_SENT;
				end
			end
			tcb_pkg::EV_SEG: begin
				if (!cmd.header_ok || st_q == tcb_pkg::ST_CLOSED) begin
					res_d.dropped = 1'b1;
				end else if (st_q == tcb_pkg::ST_SYN_SENT) begin
					if (cmd.flag_syn) begin
						rcv_nxt_d = cmd.seg_seq_p1;
						snd_una_d = una_sel;
						if (una_sel > init_seq_q) begin
							snd_wnd_d         = cmd.seg_window;
							st_d              = tcb_pkg::ST_ESTAB;
							want_ack          = 1'b1;
							res_d.wake_reader = 1'b1;
						end else begin
							st_d           = tcb_pkg::ST_SYN_RCVD;
							snd_nxt_d      = init_seq_q + 32'd1;
							res_d.tx_seq   = init_seq_q;
							res_d.tx_ack   = cmd.seg_seq_p1;
							res_d.transmit = tcb_pkg::TX_SYNACK;
						end
					end else begin
						res_d.dropped = 1'b1;
					end
				end else if (!cmd.flag_ack) begin
					res_d.dropped = 1'b1;
				end else begin
					go = 1'b1;
					case (st_q)
						tcb_pkg::ST_SYN_RCVD: begin
							if (in_win) begin
								snd_una_d         = cmd.seg_ack;
								st_d              = tcb_pkg::ST_ESTAB;
								snd_wnd_d         = cmd.seg_window;
								want_ack          = 1'b1;
								res_d.wake_reader = 1'b1;
							end else begin
								res_d.dropped = 1'b1;
								go            = 1'b0;
							end
						end
						tcb_pkg::ST_ESTAB: begin
							if (in_win) begin
								snd_una_d = cmd.seg_ack;
							end
							snd_wnd_d         = cmd.seg_window;
							res_d.wake_sender = 1'b1;
						end
						tcb_pkg::ST_FIN_WAIT1: begin
							st_d = tcb_pkg::ST_FIN_WAIT2;
						end
						default: begin
							res_d.dropped = 1'b1;
							go            = 1'b0;
						end
					endcase
					// In-order payload is stored up to the free buffer space.
					if (go && cmd.payload_nz) begin
						if (cmd.seg_seq != rcv_nxt_q) begin
							res_d.dropped = 1'b1;
							go            = 1'b0;
						end else begin
							pay_n                = seg_n;
							fill_d               = fill_q + seg_n;
							res_d.accepted_bytes = seg_n;
							if (seg_n != 16'd0) begin
								want_ack = 1'b1;
							end
							if ((fill_q + seg_n) == rcv_cap_q || cmd.flag_psh) begin
								res_d.wake_reader = 1'b1;
							end
						end
					end
					if (go && cmd.flag_fin) begin
						fin_inc = 1'b1;
						if (st_d == tcb_pkg::ST_FIN_WAIT1 || st_d == tcb_pkg::ST_FIN_WAIT2) begin
							st_d                   = tcb_pkg::ST_TIME_WAIT;
							want_ack               = 1'b1;
							res_d.start_wait_timer = 1'b1;
						end
					end
					rcv_nxt_d = rcv_nxt_q + {16'd0, pay_n} + {31'd0, fin_inc};
				end
				if (want_ack) begin
					res_d.transmit = tcb_pkg::TX_ACK;
					res_d.tx_seq   = snd_nxt_d;
					res_d.tx_ack   = rcv_nxt_d;
				end
			end
			tcb_pkg::EV_SEND: begin
				if (st_q == tcb_pkg::ST_ESTAB && snd_n != 16'd0) begin
					res_d.transmit       = tcb_pkg::TX_ACK;
					res_d.tx_seq         = snd_nxt_q;
					res_d.tx_ack         = rcv_nxt_q;
					snd_nxt_d            = snd_nxt_q + {16'd0, snd_n};
					res_d.accepted_bytes = snd_n;
				end
			end
			tcb_pkg::EV_READ: begin
				fill_d               = fill_q - rd_n;
				res_d.accepted_bytes = rd_n;
			end
			tcb_pkg::EV_EXPIRE: begin
				if (st_q == tcb_pkg::ST_TIME_WAIT) begin
					st_d              = tcb_pkg::ST_CLOSED;
					res_d.wake_reader = 1'b1;
				end
			end
			default: begin
			end
		endcase
		res_d.conn_state_now = st_d;
		res_d.rcv_fill_now   = fill_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_seq_q <= tcb_pkg::INIT_SEQ_RESET;
			rcv_cap_q  <= tcb_pkg::RCV_CAP_RESET;
			mss_q      <= tcb_pkg::MSS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				tcb_pkg::REG_INIT_SEQ: init_seq_q <= cfg_data;
				tcb_pkg::REG_RCV_CAP:  rcv_cap_q  <= cfg_data[15:0];
				tcb_pkg::REG_MSS:      mss_q      <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= tcb_pkg::ST_CLOSED;
			snd_una_q   <= '0;
			snd_nxt_q   <= '0;
			snd_wnd_q   <= '0;
			rcv_nxt_q   <= '0;
			fill_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd_pop) begin
				st_q      <= st_d;
				snd_una_q <= snd_una_d;
				snd_nxt_q <= snd_nxt_d;
				snd_wnd_q <= snd_wnd_d;
				rcv_nxt_q <= rcv_nxt_d;
				fill_q    <= fill_d;
			end
			if (cmd_pop) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			res_q <= res_d;
		end
	end

	`TCB_ASSERT_NEXT(a_drop_only_seg, cmd_pop && cmd.kind != tcb_pkg::EV_SEG, !res_q.dropped,
		"drop reported for a non-segment event")
	`TCB_ASSERT_NOW(a_syn_state, res_valid_q && res_q.transmit == tcb_pkg::TX_SYN,
		res_q.conn_state_now == tcb_pkg::ST_SYN_SENT, "SYN sent outside syn-sent")
	`TCB_ASSERT_NOW(a_timer_ack, res_valid_q && res_q.start_wait_timer,
		res_q.conn_state_now == tcb_pkg::ST_TIME_WAIT && res_q.transmit == tcb_pkg::TX_ACK,
		"wait timer started without time wait and ACK")

endmodule

`default_nettype wire

[hdl/tcp_connection_control_block_core.sv]
// Top level of the TCP connection control block: front end, command queue
// and back end. Depends on tcb_pkg, tcb_front, tcb_queue and tcb_back.
//
// Usage:
//   Events enter on the s_ channel (s_tuser carries the action code, s_tdata
//   the segment header fields and byte count). Each accepted item produces
//   exactly one result item on the m_ channel, in order. m_tuser carries the
//   transmit request code, m_tdata the sequence numbers and status.
//   Registers (initial send sequence, receive capacity, segment size) are
//   written on the cfg_ channel, which is always ready; write them only
//   while no event is in flight.
//   Path: an accepted item waits in the command queue; once the result register
//   is free it is popped and its result is loaded into that register and presented.
//   Throughput: one item per cycle while m_tready stays high. The execute stage
//   updates the whole connection state at once for each item it pops.
//   Stalls: the result register waits for m_tready; meanwhile new items fill
//   the command queue of QUEUE_DEPTH entries, and s_tready drops when it is full.
//   Reset: arst_n clears the state to closed, the sequence numbers, window and
//   receive fill to zero, the registers to their defaults and empties the queue.
`default_nettype none

module tcp_connection_control_block_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// Event input.
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// [7:0] seg_flags, [39:8] seg_seq, [71:40] seg_ack, [87:72] seg_window,
	// [103:88] seg_payload_len, [104] header_ok, [120:105] byte_count, rest zero
	input  wire logic [127:0] s_tdata,
	// [2:0] action, rest zero
	input  wire logic [7:0]   s_tuser,
	// Result output.
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// [31:0] tx_seq, [63:32] tx_ack, [66:64] conn_state_now, [67] dropped,
	// [83:68] accepted_bytes, [84] wake_reader, [85] wake_sender,
	// [86] start_wait_timer, [102:87] rcv_fill_now, rest zero
	output logic [103:0]      m_tdata,
	// [1:0] transmit, rest zero
	output logic [7:0]        m_tuser,
	// Register writes.
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);

	tcb_pkg::tcb_cmd_t    front_cmd;
	tcb_pkg::tcb_cmd_t    queue_head;
	tcb_pkg::tcb_result_t res;
	logic                 push;
	logic                 queue_full;
	logic                 queue_valid;
	logic                 pop;

	// Register writes are always taken; the execute stage reads them directly.
	assign cfg_ready = 1'b1;

	tcb_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.queue_full (queue_full),
		.push       (push),
		.cmd        (front_cmd)
	);

	tcb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (front_cmd),
		.full      (queue_full),
		.pop       (pop),
		.valid     (queue_valid),
		.head      (queue_head)
	);

	tcb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (queue_valid),
		.cmd       (queue_head),
		.cmd_pop   (pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// Pack the result fields, first field lowest.
	assign m_tdata = {1'b0, res.rcv_fill_now, res.start_wait_timer, res.wake_sender,
		res.wake_reader, res.accepted_bytes, res.dropped, res.conn_state_now,
		res.tx_ack, res.tx_seq};
	assign m_tuser = {6'd0, res.transmit};

endmodule

`default_nettype wire
